// ----- hdl/aes_cbc_block_cipher_assert.svh -----
// Assertion macros shared by the RTL; they expect clock and reset in scope.
`ifndef AES_CBC_BLOCK_CIPHER_ASSERT_SVH
`define AES_CBC_BLOCK_CIPHER_ASSERT_SVH

// same-cycle implication
`define ACBC_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define ACBC_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hdl/acbc_pkg.sv -----
package acbc_pkg;

   localparam int HALF_W  = 64;
   localparam int BLOCK_W = 128;
   localparam int WORD_W  = 32;
   localparam int CSR_AW  = 6;
   localparam int CSR_DW  = 64;
   localparam int ROW_W   = 4;   // round key rows 0..14
   localparam int WIDX_W  = 6;   // expanded word index 0..59

   typedef enum logic [2:0] {
      REG_KEY0  = 3'd0,
      REG_KEY1  = 3'd1,
      REG_KEY2  = 3'd2,
      REG_KEY3  = 3'd3,
      REG_IV_HI = 3'd4,
      REG_IV_LO = 3'd5,
      REG_MODE  = 3'd6,
      REG_DIR   = 3'd7
   } reg_index_type;

   typedef enum logic [1:0] {
      MODE_128 = 2'd0,
      MODE_192 = 2'd1,
      MODE_256 = 2'd2
   } key_mode_type;

   typedef logic [7:0] sbox_table_type [256];

   localparam sbox_table_type SBOX = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
   };

   function automatic sbox_table_type inv_build();
      sbox_table_type t;
      for (int i = 0; i < 256; i++) begin
         t[SBOX[i]] = 8'(i);
      end
      return t;
   endfunction

   localparam sbox_table_type SBOX_REV = inv_build();

   localparam logic [7:0] RCON_FIRST = 8'h01;

   function automatic logic [7:0] xt(input logic [7:0] b);
      return {b[6:0], 1'b0} ^ (b[7] ? 8'h1B : 8'h00);
   endfunction

   function automatic logic [7:0] get_byte(input logic [BLOCK_W-1:0] s, input int n);
      return s[BLOCK_W-1-8*n -: 8];
   endfunction

   function automatic logic [WORD_W-1:0] sub_word(input logic [WORD_W-1:0] w);
      return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
   endfunction

   // SubBytes + ShiftRows, or their inverses
   function automatic logic [BLOCK_W-1:0] sub_shift(input logic [BLOCK_W-1:0] s,
                                                    input logic inverse);
      logic [BLOCK_W-1:0] t;
      logic [7:0]         b;
      t = '0;
      for (int r = 0; r < 4; r++) begin
         for (int c = 0; c < 4; c++) begin
            if (inverse) begin
               b = SBOX_REV[get_byte(s, r + 4 * ((c + 4 - r) % 4))];
            end else begin
               b = SBOX[get_byte(s, r + 4 * ((c + r) % 4))];
            end
            t[BLOCK_W-1-8*(r+4*c) -: 8] = b;
         end
      end
      return t;
   endfunction

   function automatic logic [BLOCK_W-1:0] mix_fwd(input logic [BLOCK_W-1:0] s);
      logic [BLOCK_W-1:0] t;
      logic [7:0] a0, a1, a2, a3;
      t = '0;
      for (int c = 0; c < 4; c++) begin
         a0 = get_byte(s, 4*c);
         a1 = get_byte(s, 4*c+1);
         a2 = get_byte(s, 4*c+2);
         a3 = get_byte(s, 4*c+3);
         t[BLOCK_W-1-8*(4*c)   -: 8] = xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3;
         t[BLOCK_W-1-8*(4*c+1) -: 8] = a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3;
         t[BLOCK_W-1-8*(4*c+2) -: 8] = a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3;
         t[BLOCK_W-1-8*(4*c+3) -: 8] = xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3);
      end
      return t;
   endfunction

   function automatic logic [7:0] m9(input logic [7:0] b);
      return xt(xt(xt(b))) ^ b;
   endfunction
   function automatic logic [7:0] m11(input logic [7:0] b);
      return xt(xt(xt(b))) ^ xt(b) ^ b;
   endfunction
   function automatic logic [7:0] m13(input logic [7:0] b);
      return xt(xt(xt(b))) ^ xt(xt(b)) ^ b;
   endfunction
   function automatic logic [7:0] m14(input logic [7:0] b);
      return xt(xt(xt(b))) ^ xt(xt(b)) ^ xt(b);
   endfunction

   function automatic logic [BLOCK_W-1:0] mix_inv(input logic [BLOCK_W-1:0] s);
      logic [BLOCK_W-1:0] t;
      logic [7:0] a0, a1, a2, a3;
      t = '0;
      for (int c = 0; c < 4; c++) begin
         a0 = get_byte(s, 4*c);
         a1 = get_byte(s, 4*c+1);
         a2 = get_byte(s, 4*c+2);
         a3 = get_byte(s, 4*c+3);
         t[BLOCK_W-1-8*(4*c)   -: 8] = m14(a0) ^ m11(a1) ^ m13(a2) ^ m9(a3);
         t[BLOCK_W-1-8*(4*c+1) -: 8] = m9(a0) ^ m14(a1) ^ m11(a2) ^ m13(a3);
         t[BLOCK_W-1-8*(4*c+2) -: 8] = m13(a0) ^ m9(a1) ^ m14(a2) ^ m11(a3);
         t[BLOCK_W-1-8*(4*c+3) -: 8] = m11(a0) ^ m13(a1) ^ m9(a2) ^ m14(a3);
      end
      return t;
   endfunction

endpackage

// ----- hdl/acbc_if.sv -----
interface acbc_req_if;
   import acbc_pkg::*;
   logic              valid;
   logic              ready;
   logic [HALF_W-1:0] block_upper;
   logic [HALF_W-1:0] block_lower;
   logic              start_of_message;
   modport source (output valid, block_upper, block_lower, start_of_message, input ready);
   modport sink   (input valid, block_upper, block_lower, start_of_message, output ready);
endinterface

interface acbc_rsp_if;
   import acbc_pkg::*;
   logic              valid;
   logic              ready;
   logic [HALF_W-1:0] out_upper;
   logic [HALF_W-1:0] out_lower;
   modport source (output valid, out_upper, out_lower, input ready);
   modport sink   (input valid, out_upper, out_lower, output ready);
endinterface

// ----- hdl/aes_cbc_block_cipher.sv -----
// AES-CBC block cipher, 128/192/256-bit keys.
// req: one 16-byte block per transfer (block_upper holds bytes 0..7) plus
//   start_of_message, which reloads the chain from the IV registers.
// rsp: one 16-byte result per request transfer, in order.
// csr: APB-style writes of key, IV, key length and direction registers; a
//   write to a key or key length register re-expands the round keys, one
//   word per cycle (44, 52 or 60 words), while req.ready stays low.
// Round keys live in a 4-word-wide memory read one row per round; the
//   single AES round unit runs one round per cycle unless the last round
//   waits for the output register, and a new block is taken only once
//   the previous one has left the round loop.
// Reset clears the configuration registers, FSM, rsp.valid and chain to
//   zero and expands the all-zero 128-bit key before the first request.
// A stalled rsp holds its result; the last round then waits until the
//   output register frees, and no new block is taken meanwhile.
`include "aes_cbc_block_cipher_assert.svh"
module aes_cbc_block_cipher #(
   parameter int ROUND_KEY_DEPTH = 60
) (
   input  logic                        clock,
   input  logic                        reset,
   acbc_req_if.sink                    req,
   acbc_rsp_if.source                  rsp,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [acbc_pkg::CSR_AW-1:0] csr_paddr,
   input  logic [acbc_pkg::CSR_DW-1:0] csr_pwdata,
   output logic [acbc_pkg::CSR_DW-1:0] csr_prdata,
   output logic                        csr_pready
);
   import acbc_pkg::*;

   localparam int ROW_DEPTH = (ROUND_KEY_DEPTH + 3) / 4;
   localparam int ROW_AW    = $clog2(ROW_DEPTH);
   localparam logic [WIDX_W-1:0] DEPTH_LIM = WIDX_W'(ROUND_KEY_DEPTH);

   typedef enum logic {IDLE, RUN} fsm_type;

   // ---------------- configuration registers
   logic [HALF_W-1:0] key_ff [4];
   logic [HALF_W-1:0] iv_hi_ff, iv_lo_ff;
   logic [1:0]        mode_ff;
   logic              dir_ff;
   logic              csr_wr, key_wr;
   reg_index_type     csr_idx;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_idx    = reg_index_type'(csr_paddr[5:3]);
   assign key_wr     = csr_wr && (csr_idx == REG_KEY0 || csr_idx == REG_KEY1 ||
                       csr_idx == REG_KEY2 || csr_idx == REG_KEY3 || csr_idx == REG_MODE);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 4; i++) key_ff[i] <= '0;
         iv_hi_ff <= '0;
         iv_lo_ff <= '0;
         mode_ff  <= MODE_128;
         dir_ff   <= 1'b0;
      end else if (csr_wr) begin
         unique case (csr_idx)
            REG_KEY0:  key_ff[0] <= csr_pwdata;
            REG_KEY1:  key_ff[1] <= csr_pwdata;
            REG_KEY2:  key_ff[2] <= csr_pwdata;
            REG_KEY3:  key_ff[3] <= csr_pwdata;
            REG_IV_HI: iv_hi_ff  <= csr_pwdata;
            REG_IV_LO: iv_lo_ff  <= csr_pwdata;
            REG_MODE:  mode_ff   <= csr_pwdata[1:0];
            REG_DIR:   dir_ff    <= csr_pwdata[0];
            default:   ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         REG_KEY0:  csr_prdata = key_ff[0];
         REG_KEY1:  csr_prdata = key_ff[1];
         REG_KEY2:  csr_prdata = key_ff[2];
         REG_KEY3:  csr_prdata = key_ff[3];
         REG_IV_HI: csr_prdata = iv_hi_ff;
         REG_IV_LO: csr_prdata = iv_lo_ff;
         REG_MODE:  csr_prdata = {{(CSR_DW-2){1'b0}}, mode_ff};
         REG_DIR:   csr_prdata = {{(CSR_DW-1){1'b0}}, dir_ff};
         default:   csr_prdata = '0;
      endcase
   end

   // key words, rounds, expanded length
   logic [3:0]        nk, nr;
   logic [WIDX_W-1:0] total;
   always_comb begin
      case (mode_ff)
         MODE_128: nk = 4'd4;
         MODE_192: nk = 4'd6;
         default:  nk = 4'd8;   // mode three acts as 256-bit
      endcase
      nr    = nk + 4'd6;
      total = {nk + 4'd7, 2'b00};
   end

   // ---------------- key expansion, one word per cycle
   logic              exp_run_ff;
   logic [WIDX_W-1:0] exp_idx_ff;
   logic [2:0]        exp_pos_ff;
   logic [7:0]        rcon_ff;
   logic [WORD_W-1:0] hist_ff [8];   // hist_ff[k] = w[i-1-k]
   logic [WORD_W-1:0] exp_word, exp_t, key_word;
   logic [HALF_W-1:0] key_half;
   logic              exp_in_key, exp_we;
   logic [2:0]        nk_last;

   assign nk_last    = 3'(nk - 4'd1);
   assign exp_in_key = exp_idx_ff < WIDX_W'(nk);
   assign key_half   = key_ff[exp_idx_ff[2:1]];
   assign key_word   = exp_idx_ff[0] ? key_half[WORD_W-1:0] : key_half[HALF_W-1:WORD_W];

   always_comb begin
      exp_t = hist_ff[0];
      if (exp_pos_ff == 3'd0) begin
         exp_t = sub_word({hist_ff[0][23:0], hist_ff[0][31:24]}) ^ {rcon_ff, 24'h0};
      end else if (nk == 4'd8 && exp_pos_ff == 3'd4) begin
         exp_t = sub_word(hist_ff[0]);
      end
      exp_word = exp_in_key ? key_word : (hist_ff[nk_last] ^ exp_t);
   end

   assign exp_we = exp_run_ff && (exp_idx_ff < DEPTH_LIM);

   always_ff @(posedge clock) begin
      if (reset || key_wr) begin
         exp_run_ff <= 1'b1;
         exp_idx_ff <= '0;
         exp_pos_ff <= '0;
         rcon_ff    <= RCON_FIRST;
      end else if (exp_run_ff) begin
         exp_idx_ff <= exp_idx_ff + 1'b1;
         exp_pos_ff <= (exp_pos_ff == nk_last) ? 3'd0 : exp_pos_ff + 3'd1;
         if (!exp_in_key && exp_pos_ff == 3'd0) rcon_ff <= xt(rcon_ff);
         if (exp_idx_ff == total - 1'b1) exp_run_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (exp_run_ff) begin
         hist_ff[0] <= exp_word;
         for (int k = 1; k < 8; k++) hist_ff[k] <= hist_ff[k-1];
      end
   end

   // ---------------- round key memory: one row of four words per round
   logic [3:0][WORD_W-1:0] rk_mem [ROW_DEPTH];
   logic [3:0][WORD_W-1:0] rk_rd_ff;
   logic [3:0]             rk_mask_ff, rk_mask_in;
   logic [ROW_W-1:0]       rd_row_ff, rd_row_in;
   logic [BLOCK_W-1:0]     rk;

   always_comb begin
      for (int c = 0; c < 4; c++) begin
         rk_mask_in[c] = {rd_row_in, 2'(c)} < DEPTH_LIM;
      end
   end

   always_ff @(posedge clock) begin
      if (exp_we) rk_mem[exp_idx_ff[ROW_AW+1:2]][exp_idx_ff[1:0]] <= exp_word;
      rk_rd_ff   <= rk_mem[rd_row_in[ROW_AW-1:0]];
      rk_mask_ff <= rk_mask_in;
   end

   assign rk = {rk_mask_ff[0] ? rk_rd_ff[0] : '0, rk_mask_ff[1] ? rk_rd_ff[1] : '0,
                rk_mask_ff[2] ? rk_rd_ff[2] : '0, rk_mask_ff[3] ? rk_rd_ff[3] : '0};

   // ---------------- round engine
   fsm_type            fsm_ff;
   logic [3:0]         round_ff;
   logic [BLOCK_W-1:0] state_ff, blk_ff, chain_ff, state_in, chain_sel, blk_in;
   logic [BLOCK_W-1:0] enc_sb, dec_u;
   logic               rsp_valid_ff, out_free, accept, last;
   logic [HALF_W-1:0]  out_hi_ff, out_lo_ff;

   assign req.ready = (fsm_ff == IDLE) && !exp_run_ff;
   assign accept    = req.valid && req.ready;
   assign out_free  = !rsp_valid_ff || rsp.ready;
   assign last      = round_ff == nr;
   assign blk_in    = {req.block_upper, req.block_lower};
   assign chain_sel = req.start_of_message ? {iv_hi_ff, iv_lo_ff} : chain_ff;

   always_comb begin
      enc_sb = sub_shift(state_ff, 1'b0);
      dec_u  = sub_shift(state_ff, 1'b1) ^ rk;
      if (round_ff == 4'd0) begin
         state_in = state_ff ^ rk;
      end else if (!dir_ff) begin
         state_in = last ? (enc_sb ^ rk) : (mix_fwd(enc_sb) ^ rk);
      end else begin
         state_in = last ? dec_u : mix_inv(dec_u);
      end
   end

   always_comb begin
      rd_row_in = rd_row_ff;
      if (accept) begin
         rd_row_in = dir_ff ? nr : '0;
      end else if (fsm_ff == RUN && !last) begin
         rd_row_in = dir_ff ? nr - round_ff - 4'd1 : round_ff + 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      rd_row_ff <= rd_row_in;
      if (reset) begin
         fsm_ff       <= IDLE;
         round_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         chain_ff     <= '0;
      end else begin
         // a result finishing this cycle refills the output register
         if (rsp_valid_ff && rsp.ready && !(fsm_ff == RUN && last && out_free)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (fsm_ff)
            IDLE: begin
               if (accept) begin
                  state_ff <= dir_ff ? blk_in : (blk_in ^ chain_sel);
                  blk_ff   <= blk_in;
                  chain_ff <= chain_sel;
                  round_ff <= '0;
                  fsm_ff   <= RUN;
               end
            end
            RUN: begin
               if (!last) begin
                  state_ff <= state_in;
                  round_ff <= round_ff + 4'd1;
               end else if (out_free) begin
                  if (dir_ff) begin
                     {out_hi_ff, out_lo_ff} <= state_in ^ chain_ff;
                     chain_ff               <= blk_ff;
                  end else begin
                     {out_hi_ff, out_lo_ff} <= state_in;
                     chain_ff               <= state_in;
                  end
                  rsp_valid_ff <= 1'b1;
                  round_ff     <= '0;
                  fsm_ff       <= IDLE;
               end
            end
            default: fsm_ff <= IDLE;
         endcase
      end
   end

   assign rsp.valid     = rsp_valid_ff;
   assign rsp.out_upper = out_hi_ff;
   assign rsp.out_lower = out_lo_ff;

   `ACBC_ASSERT_NEXT(a_accept_starts, accept, fsm_ff == RUN && round_ff == 4'd0,
      "accepted block did not start at round zero")
   `ACBC_ASSERT_NOW(a_no_expand_in_run, fsm_ff == RUN, !exp_run_ff,
      "key expansion overlaps a running block")
   `ACBC_ASSERT_NOW(a_result_from_run, $rose(rsp_valid_ff), $past(fsm_ff == RUN && last),
      "result raised without a finished last round")
   `ACBC_ASSERT_NOW(a_round_bound, fsm_ff == RUN, round_ff <= nr,
      "round counter passed the round count")

endmodule
